[rtl/ugl_pkg.sv]
// shared widths, codes and state type for the uniform grid lerp table
package ugl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int SCALE_W = 25;
    localparam int TIME_W  = 40;
    localparam int PTS_W   = 11;
    localparam int IDX_W   = 10;
    localparam int OP_W    = 2;
    localparam int CODE_W  = 2;
    localparam int CFG_W   = 25;
    localparam int CFG_IDX_W = 2;

    // shared multiplier: 20 bit slice times 25 bit factor
    localparam int MUL_A_W = 20;
    localparam int MUL_P_W = MUL_A_W + SCALE_W;
    // product / dividend width and divisor width of the serial divider
    localparam int PROD_W  = TIME_W + SCALE_W;
    localparam int DIV_D_W = TIME_W;
    localparam int SUM_W   = 43;

    localparam logic [SCALE_W-1:0] SCALE_MAX      = '1;
    localparam logic [SCALE_W-1:0] GRID_START_RST = 25'd0;
    localparam logic [SCALE_W-1:0] GRID_STEP_RST  = 25'd16384;
    localparam logic [SCALE_W-1:0] GRID_END_RST   = 25'd16777216;
    localparam logic [PTS_W-1:0]   POINTS_RST     = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_FORWARD = 2'd1,
        OP_INVERSE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [CODE_W-1:0] {
        CLAMP_NONE  = 2'd0,
        CLAMP_START = 2'd1,
        CLAMP_END   = 2'd2,
        CLAMP_RSVD  = 2'd3
    } t_clamp;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_START = 2'd0,
        CFG_GRID_STEP  = 2'd1,
        CFG_GRID_END   = 2'd2,
        CFG_POINTS     = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLAMP_T,
        S_F_WAITA,
        S_F_RDLO,
        S_F_RDUP,
        S_F_MULH,
        S_F_MULL,
        S_F_DIVB,
        S_F_WAITB,
        S_I_FIRST,
        S_I_LAST,
        S_I_SRCH,
        S_I_CMP,
        S_I_MULH,
        S_I_MULL,
        S_I_DIVS,
        S_I_WAIT,
        S_I_BASE,
        S_DONE
    } t_state;

endpackage

[rtl/ugl_table_ram.sv]
// single port time table memory with registered read data
module ugl_table_ram #(
    parameter int DEPTH = ugl_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_addr,
    input  logic [ugl_pkg::TIME_W-1:0] i_wdata,
    output logic [ugl_pkg::TIME_W-1:0] o_rdata
);
    import ugl_pkg::*;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ugl_div.sv]
// restoring serial divider, one quotient bit per cycle
module ugl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ugl_pkg::PROD_W-1:0]  i_dividend,
    input  logic [ugl_pkg::DIV_D_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [ugl_pkg::PROD_W-1:0]  o_quotient,
    output logic [ugl_pkg::DIV_D_W-1:0] o_remainder
);
    import ugl_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PROD_W-1:0]  r_quo, n_quo;
    logic [DIV_D_W:0]   r_rem, n_rem;
    logic [DIV_D_W-1:0] r_div, n_div;
    logic [DIV_D_W:0]   rem_sh;
    logic               fits;

    always_comb begin
        rem_sh = {r_rem[DIV_D_W-1:0], r_quo[PROD_W-1]};
        fits   = rem_sh >= {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? rem_sh - {1'b0, r_div} : rem_sh;
            n_quo = {r_quo[PROD_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(PROD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[DIV_D_W-1:0];

endmodule

[rtl/uniform_grid_lerp_table_with_inverse.sv]
// top level: time table with linear interpolation and exact inverse
//
//  channel   direction  handshake               payload
//  input     in         i_valid / o_stall       i_op, i_entry_index, i_scale_factor,
//                                               i_time_value
//  output    out        o_valid / i_stall       o_result_time, o_result_scale,
//                                               o_clamp_code
//  config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
//  one transaction at a time; o_stall is high from acceptance until the result
//  moves into the output register
//  load and clamped ops do not use the divider; forward inside the grid uses the
//  serial divider twice and inverse inside the table uses it once; the inverse
//  also takes one table read per binary search step
//  synchronous active low reset clears control state and loads the config registers
//  with their defaults, the table is undefined until written; a stalled output holds and the next
//  transaction may be accepted meanwhile
module uniform_grid_lerp_table_with_inverse #(
    parameter int TABLE_DEPTH = ugl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ugl_pkg::OP_W-1:0]      i_op,
    input  logic [ugl_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [ugl_pkg::SCALE_W-1:0]   i_scale_factor,
    input  logic [ugl_pkg::TIME_W-1:0]    i_time_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ugl_pkg::TIME_W-1:0]    o_result_time,
    output logic [ugl_pkg::SCALE_W-1:0]   o_result_scale,
    output logic [ugl_pkg::CODE_W-1:0]    o_clamp_code,
    input  logic                          i_cfg_we,
    input  logic [ugl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ugl_pkg::CFG_W-1:0]     i_cfg_data
);
    import ugl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;

    // config registers
    logic [SCALE_W-1:0] r_grid_start, r_grid_step, r_grid_end;
    logic [PTS_W-1:0]   r_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_start <= GRID_START_RST;
            r_grid_step  <= GRID_STEP_RST;
            r_grid_end   <= GRID_END_RST;
            r_points     <= POINTS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_START: r_grid_start <= i_cfg_data;
                CFG_GRID_STEP:  r_grid_step  <= i_cfg_data;
                CFG_GRID_END:   r_grid_end   <= i_cfg_data;
                CFG_POINTS:     r_points     <= i_cfg_data[PTS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SCALE_W-1:0] step_eff;
    logic [NW-1:0]      n_eff;
    logic [AW-1:0]      last_idx;

    always_comb begin
        step_eff = (r_grid_step == '0) ? SCALE_W'(1) : r_grid_step;
        if (r_points < PTS_W'(2)) begin
            n_eff = NW'(2);
        end else if (int'(r_points) > TABLE_DEPTH) begin
            n_eff = NW'(TABLE_DEPTH);
        end else begin
            n_eff = NW'(r_points);
        end
        last_idx = AW'(n_eff - NW'(1));
    end

    // datapath registers
    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_t, n_t;
    logic [AW-1:0]      r_j, n_j;
    logic [SCALE_W-1:0] r_ld, n_ld;
    logic [TIME_W-1:0]  r_lo_val, n_lo_val;
    logic [TIME_W-1:0]  r_hi_val, n_hi_val;
    logic [AW-1:0]      r_lo, n_lo;
    logic [AW-1:0]      r_hi, n_hi;
    logic [AW-1:0]      r_mid, n_mid;
    logic [TIME_W-1:0]  r_diff, n_diff;
    logic               r_down, n_down;
    logic [PROD_W-1:0]  r_acc, n_acc;
    logic [TIME_W-1:0]  r_res_time, n_res_time;
    logic [SCALE_W-1:0] r_res_scale, n_res_scale;
    t_clamp             r_code, n_code;
    logic               r_out_valid, n_out_valid;
    logic [TIME_W-1:0]  r_out_time, n_out_time;
    logic [SCALE_W-1:0] r_out_scale, n_out_scale;
    t_clamp             r_out_code, n_out_code;

    // table memory
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [TIME_W-1:0]  ram_rdata;

    ugl_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_time_value),
        .o_rdata (ram_rdata)
    );

    // serial divider
    logic               div_start;
    logic               div_done;
    logic [PROD_W-1:0]  div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [PROD_W-1:0]  div_quo;
    logic [DIV_D_W-1:0] div_rem;

    ugl_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [SCALE_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    logic              in_acc, out_free;
    logic [SCALE_W-1:0] off;
    logic [AW-1:0]     mid_calc;
    logic [SUM_W-1:0]  scale_sum;
    logic [TIME_W-1:0] quo_t;

    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign off      = i_scale_factor - r_grid_start;
    assign mid_calc = r_lo + ((r_hi - r_lo) >> 1);
    assign quo_t    = div_quo[TIME_W-1:0];
    assign scale_sum = SUM_W'(r_grid_start) + SUM_W'(mul_p) + SUM_W'(div_quo[SCALE_W:0]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (t_op'(i_op))
                        OP_FORWARD: begin
                            if (i_scale_factor <= r_grid_start ||
                                i_scale_factor >= r_grid_end) begin
                                n_state = S_CLAMP_T;
                            end else begin
                                n_state = S_F_WAITA;
                            end
                        end
                        OP_INVERSE: n_state = S_I_FIRST;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_CLAMP_T: n_state = S_DONE;
            S_F_WAITA: if (div_done) n_state = S_F_RDLO;
            S_F_RDLO:  n_state = S_F_RDUP;
            S_F_RDUP:  n_state = S_F_MULH;
            S_F_MULH:  n_state = S_F_MULL;
            S_F_MULL:  n_state = S_F_DIVB;
            S_F_DIVB:  n_state = S_F_WAITB;
            S_F_WAITB: if (div_done) n_state = S_DONE;
            S_I_FIRST: n_state = S_I_LAST;
            S_I_LAST: begin
                if (r_t <= r_lo_val || r_t >= ram_rdata) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_I_SRCH;
                end
            end
            S_I_SRCH:  n_state = (r_hi - r_lo > AW'(1)) ? S_I_CMP : S_I_MULH;
            S_I_CMP:   n_state = S_I_SRCH;
            S_I_MULH:  n_state = S_I_MULL;
            S_I_MULL:  n_state = S_I_DIVS;
            S_I_DIVS:  n_state = S_I_WAIT;
            S_I_WAIT:  if (div_done) n_state = S_I_BASE;
            S_I_BASE:  n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_t         = r_t;
        n_j         = r_j;
        n_ld        = r_ld;
        n_lo_val    = r_lo_val;
        n_hi_val    = r_hi_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_diff      = r_diff;
        n_down      = r_down;
        n_acc       = r_acc;
        n_res_time  = r_res_time;
        n_res_scale = r_res_scale;
        n_code      = r_code;
        n_out_valid = r_out_valid && i_stall;
        n_out_time  = r_out_time;
        n_out_scale = r_out_scale;
        n_out_code  = r_out_code;
        ram_we        = 1'b0;
        ram_addr      = '0;
        div_start     = 1'b0;
        div_dividend  = PROD_W'(off);
        div_divisor   = DIV_D_W'(step_eff);
        mul_a         = r_diff[TIME_W-1:MUL_A_W];
        mul_b         = r_ld;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_t         = i_time_value;
                    n_res_time  = '0;
                    n_res_scale = '0;
                    n_code      = CLAMP_NONE;
                    unique case (t_op'(i_op))
                        OP_LOAD: begin
                            if (int'(i_entry_index) < TABLE_DEPTH) begin
                                ram_we   = 1'b1;
                                ram_addr = AW'(i_entry_index);
                            end
                        end
                        OP_FORWARD: begin
                            if (i_scale_factor <= r_grid_start) begin
                                n_code = CLAMP_START;
                            end else if (i_scale_factor >= r_grid_end) begin
                                ram_addr = last_idx;
                                n_code   = CLAMP_END;
                            end else begin
                                div_start = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLAMP_T: n_res_time = ram_rdata;
            S_F_WAITA: begin
                if (div_done) begin
                    // interval past the table: last interval, full step
                    if (div_quo > PROD_W'(n_eff - NW'(2))) begin
                        n_j      = AW'(n_eff - NW'(2));
                        n_ld     = step_eff;
                    end else begin
                        n_j      = AW'(div_quo);
                        n_ld     = div_rem[SCALE_W-1:0];
                    end
                    ram_addr = n_j;
                end
            end
            S_F_RDLO: begin
                n_lo_val = ram_rdata;
                ram_addr = r_j + AW'(1);
            end
            S_F_RDUP: begin
                n_down = ram_rdata < r_lo_val;
                n_diff = n_down ? r_lo_val - ram_rdata : ram_rdata - r_lo_val;
            end
            S_F_MULH: n_acc = {mul_p, {MUL_A_W{1'b0}}};
            S_F_MULL: begin
                mul_a = r_diff[MUL_A_W-1:0];
                n_acc = r_acc + PROD_W'(mul_p);
            end
            S_F_DIVB: begin
                div_start     = 1'b1;
                div_dividend  = r_acc;
            end
            S_F_WAITB: begin
                // falling interval rounds the drop up so the result truncates
                if (r_down) begin
                    n_res_time = r_lo_val - quo_t - TIME_W'(div_rem != '0);
                end else begin
                    n_res_time = r_lo_val + quo_t;
                end
            end
            S_I_FIRST: begin
                n_lo_val = ram_rdata;
                ram_addr = last_idx;
            end
            S_I_LAST: begin
                n_hi_val = ram_rdata;
                n_lo     = '0;
                n_hi     = last_idx;
                if (r_t <= r_lo_val) begin
                    n_res_scale = r_grid_start;
                    n_code      = CLAMP_START;
                end else if (r_t >= ram_rdata) begin
                    n_res_scale = r_grid_end;
                    n_code      = CLAMP_END;
                end
            end
            S_I_SRCH: begin
                n_mid    = mid_calc;
                ram_addr = mid_calc;
                n_diff   = r_t - r_lo_val;
            end
            S_I_CMP: begin
                if (ram_rdata <= r_t) begin
                    n_lo     = r_mid;
                    n_lo_val = ram_rdata;
                end else begin
                    n_hi     = r_mid;
                    n_hi_val = ram_rdata;
                end
            end
            S_I_MULH: begin
                mul_b = step_eff;
                n_acc = {mul_p, {MUL_A_W{1'b0}}};
            end
            S_I_MULL: begin
                mul_a = r_diff[MUL_A_W-1:0];
                mul_b = step_eff;
                n_acc = r_acc + PROD_W'(mul_p);
            end
            S_I_DIVS: begin
                div_start     = 1'b1;
                div_dividend  = r_acc;
                div_divisor   = r_hi_val - r_lo_val;
            end
            S_I_BASE: begin
                mul_a = MUL_A_W'(r_lo);
                mul_b = step_eff;
                n_res_scale = (scale_sum > SUM_W'(SCALE_MAX)) ? SCALE_MAX
                                                              : scale_sum[SCALE_W-1:0];
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_time  = r_res_time;
                    n_out_scale = r_res_scale;
                    n_out_code  = r_code;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_t         <= n_t;
        r_j         <= n_j;
        r_ld        <= n_ld;
        r_lo_val    <= n_lo_val;
        r_hi_val    <= n_hi_val;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_diff      <= n_diff;
        r_down      <= n_down;
        r_acc       <= n_acc;
        r_res_time  <= n_res_time;
        r_res_scale <= n_res_scale;
        r_code      <= n_code;
        r_out_time  <= n_out_time;
        r_out_scale <= n_out_scale;
        r_out_code  <= n_out_code;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_result_time  = r_out_time;
    assign o_result_scale = r_out_scale;
    assign o_clamp_code   = r_out_code;

endmodule

[rtl/ugl_checker.sv]
// port level checks for the lerp table, bound to the top level
module ugl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [ugl_pkg::TIME_W-1:0]  o_result_time,
    input logic [ugl_pkg::SCALE_W-1:0] o_result_scale,
    input logic [ugl_pkg::CODE_W-1:0]  o_clamp_code
);
    import ugl_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_time) &&
        $stable(o_result_scale) && $stable(o_clamp_code))
        else $error("output changed while stalled");

    // only one kind of result is ever nonzero
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_time == '0 || o_result_scale == '0))
        else $error("both result fields nonzero");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_clamp_code != CLAMP_RSVD)
        else $error("reserved clamp code");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted twice in a row");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind uniform_grid_lerp_table_with_inverse ugl_checker u_ugl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_time  (o_result_time),
    .o_result_scale (o_result_scale),
    .o_clamp_code   (o_clamp_code)
);
